// ===== design/lcdpk_pkg.sv =====
// Types and constants shared by the 9-bit LCD pixel packer.
// No dependencies. Imported by every module of the block.
`default_nettype none

package lcdpk_pkg;

  localparam int PIX_W       = 12;
  localparam int BYTE_W      = 8;
  localparam int GRP_BYTES   = 5;   // most bytes one pixel pair can produce
  localparam int GRP_CNT_W   = 3;
  localparam int RES_W       = 7;   // leftover stream bits kept between pairs
  localparam int RES_CNT_W   = 3;
  localparam int PAIR_BITS   = 27;  // three 9-bit words
  localparam int STREAM_W    = RES_W + PAIR_BITS;
  localparam int ALIGN_W     = GRP_BYTES * BYTE_W;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_frame;
  } pix_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_burst;
  } byte_word_t;

  // Bytes produced by one pixel pair; entry 0 goes out first.
  typedef struct packed {
    logic [GRP_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [GRP_CNT_W-1:0]             count;
    logic                             last;   // final byte closes the burst
  } byte_grp_t;

endpackage

`default_nettype wire

// ===== design/lcdpk_pack.sv =====
// Input register, pixel pairing and bit packing for the 9-bit LCD packer.
// Depends on lcdpk_pkg. Hands one byte group per pixel pair to lcdpk_emit.
`default_nettype none

module lcdpk_pack #(
  parameter int BURST_PIXELS = 128
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  lcdpk_pkg::pix_word_t in_data,
  output logic                 in_stall,
  output logic                 grp_vld,
  output lcdpk_pkg::byte_grp_t grp,
  input  wire                  grp_free
);
  import lcdpk_pkg::*;

  localparam int CNT_W = $clog2(BURST_PIXELS);

  pix_word_t          in_r;
  logic               in_vld_r;
  logic [PIX_W-1:0]   held_pixel_r;
  logic               held_vld_r;
  logic [RES_W-1:0]   residue_r, residue_nxt;
  logic [RES_CNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]   burst_cnt_r, burst_cnt_nxt;

  logic               hold_only;
  logic               adv;
  logic               flush;
  logic [PIX_W-1:0]   p0, p1;
  logic [PAIR_BITS-1:0] words;
  logic [RES_W-1:0]   res_mask, rem_mask;
  logic [STREAM_W-1:0] stream;
  logic [ALIGN_W-1:0] aligned;
  logic [5:0]         tot_bits;
  logic [GRP_CNT_W-1:0] nfull;
  logic [RES_CNT_W-1:0] rem;

  assign hold_only = !held_vld_r && !in_r.end_of_frame;
  // A held-only word never needs the emitter, so it moves on regardless.
  assign adv       = in_vld_r && (hold_only || grp_free);
  assign in_stall  = in_vld_r && !adv;
  assign grp_vld   = in_vld_r && !hold_only && grp_free;

  always_comb begin
    if (held_vld_r) begin
      p0 = held_pixel_r;
      p1 = in_r.pixel;
    end else begin
      p0 = in_r.pixel;
      p1 = '0;
    end
    words = {1'b1, p0[11:4], 1'b1, p0[3:0], p1[11:8], 1'b1, p1[7:0]};

    res_mask = RES_W'((8'd1 << rcnt_r) - 8'd1);
    stream   = {residue_r & res_mask, words};
    // Left-align the valid bits so byte 0 sits at the top; pad bits come in as zero.
    aligned  = {stream, 6'b0} << (3'd7 - rcnt_r);

    tot_bits = 6'(PAIR_BITS) + 6'(rcnt_r);
    nfull    = GRP_CNT_W'(tot_bits >> 3);
    rem      = tot_bits[2:0];
    rem_mask = RES_W'((8'd1 << rem) - 8'd1);

    flush = in_r.end_of_frame ||
            (({1'b0, burst_cnt_r} + (CNT_W+1)'(2)) >= (CNT_W+1)'(BURST_PIXELS));

    for (int i = 0; i < GRP_BYTES; i++) begin
      grp.bytes[i] = aligned[ALIGN_W-1-BYTE_W*i -: BYTE_W];
    end
    grp.count = nfull + GRP_CNT_W'(flush && (rem != '0));
    grp.last  = flush;

    if (flush) begin
      residue_nxt   = '0;
      rcnt_nxt      = '0;
      burst_cnt_nxt = '0;
    end else begin
      residue_nxt   = stream[RES_W-1:0] & rem_mask;
      rcnt_nxt      = rem;
      burst_cnt_nxt = burst_cnt_r + CNT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      held_vld_r   <= 1'b0;
      held_pixel_r <= '0;
      residue_r    <= '0;
      rcnt_r       <= '0;
      burst_cnt_r  <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
        in_r     <= in_data;
      end
      if (adv) begin
        if (hold_only) begin
          held_pixel_r <= in_r.pixel;
          held_vld_r   <= 1'b1;
        end else begin
          held_pixel_r <= '0;
          held_vld_r   <= 1'b0;
          residue_r    <= residue_nxt;
          rcnt_r       <= rcnt_nxt;
          burst_cnt_r  <= burst_cnt_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lcdpk_emit.sv =====
// Result register of the 9-bit LCD packer: holds one byte group and sends
// it one byte per word. Depends on lcdpk_pkg.
`default_nettype none

module lcdpk_emit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   grp_load,
  input  lcdpk_pkg::byte_grp_t  grp,
  output logic                  grp_free,
  output logic                  out_valid,
  output lcdpk_pkg::byte_word_t out_data,
  input  wire                   out_stall
);
  import lcdpk_pkg::*;

  byte_grp_t            grp_r;
  logic                 grp_vld_r;
  logic [GRP_CNT_W-1:0] idx_r;
  logic                 out_acc;
  logic                 at_end;
  logic                 done;

  assign at_end   = (idx_r == GRP_CNT_W'(grp_r.count - GRP_CNT_W'(1)));
  assign out_acc  = grp_vld_r && !out_stall;
  assign done     = out_acc && at_end;
  assign grp_free = !grp_vld_r || done;

  assign out_valid              = grp_vld_r;
  assign out_data.out_byte      = grp_r.bytes[idx_r];
  assign out_data.last_of_burst = grp_r.last && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (grp_load) begin
        grp_vld_r <= 1'b1;
        grp_r     <= grp;
        idx_r     <= '0;
      end else if (done) begin
        grp_vld_r <= 1'b0;
      end else if (out_acc) begin
        idx_r <= idx_r + GRP_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lcd_9bit_pixel_packer_core.sv =====
// Top level of the 9-bit LCD pixel packer: pairs 12-bit pixels into three
// 9-bit words and sends them as a byte stream. Uses lcdpk_pack, lcdpk_emit.
//
//   channel | ports                          | word
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | pixel, end_of_frame
//   output  | out_valid, out_stall, out_data | out_byte, last_of_burst
//
// A pixel word waits in the input register; a pair's 3 to 5 bytes then leave
// from the result register at one byte per cycle while out_stall is low.
// The next group loads in the cycle its predecessor's last byte is taken.
// Synchronous active-low reset clears held pixel, residue, burst count and both valid flags.
// out_stall holds the current byte; back-pressure reaches in_stall directly.
`default_nettype none

module lcd_9bit_pixel_packer_core #(
  parameter int BURST_PIXELS = 128
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  lcdpk_pkg::pix_word_t  in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output lcdpk_pkg::byte_word_t out_data,
  input  wire                   out_stall
);
  import lcdpk_pkg::*;

  logic      grp_vld;
  logic      grp_free;
  byte_grp_t grp;

  lcdpk_pack #(
    .BURST_PIXELS(BURST_PIXELS)
  ) u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .grp_vld  (grp_vld),
    .grp      (grp),
    .grp_free (grp_free)
  );

  lcdpk_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_load  (grp_vld),
    .grp       (grp),
    .grp_free  (grp_free),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire
